@@ rtl/akf_pkg.sv @@
// Shared types, constants and helpers for the angle Kalman filter.
package akf_pkg;

  localparam int COV_FRAC_BITS = 24;
  localparam int DT_FRAC_BITS  = 16;
  localparam int MUL_AW        = 36;
  localparam int MUL_BW        = 33;
  localparam int PROD_W        = MUL_AW + 1 + MUL_BW;
  localparam int WIDE_W        = 72;
  localparam int CFG_IDX_W     = 2;
  localparam int NOISE_W       = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_Q_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_BIAS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_R_MEAS  = 2'd2;

  localparam logic [NOISE_W-1:0] Q_ANGLE_RST = 31'd16777;
  localparam logic [NOISE_W-1:0] Q_BIAS_RST  = 31'd50332;
  localparam logic [NOISE_W-1:0] R_MEAS_RST  = 31'd503316;
  localparam logic signed [31:0] COV_ONE     = 32'sd1 <<< COV_FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;
    logic        [15:0] time_step;
  } akf_in_t;

  typedef struct packed {
    logic signed [31:0] angle_out;
    logic signed [31:0] bias_out;
    logic               saturated;
  } akf_out_t;

  typedef struct packed {
    logic        flag;
    logic signed [31:0] val;
  } akf_sat_t;

  function automatic akf_sat_t sat32(input logic signed [WIDE_W-1:0] x);
    akf_sat_t r;
    r.flag = 1'b0;
    r.val  = x[31:0];
    if (x > WIDE_W'(64'sh7FFF_FFFF)) begin
      r.flag = 1'b1;
      r.val  = 32'sh7FFF_FFFF;
    end else if (x < -WIDE_W'(64'sh8000_0000)) begin
      r.flag = 1'b1;
      r.val  = 32'sh8000_0000;
    end
    return r;
  endfunction

endpackage

@@ rtl/akf_mul.sv @@
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module akf_mul
  import akf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     short_op,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic                     done,
  output logic signed [PROD_W-1:0] prod
);

  logic                     busy_r;
  logic                     done_r;
  logic                     short_r;
  logic [5:0]               cnt_r;
  logic signed [MUL_AW-1:0] a_r;
  logic signed [MUL_AW:0]   hi_r;
  logic [MUL_BW-1:0]        lo_r;
  logic signed [MUL_AW:0]   addend;
  logic signed [MUL_AW:0]   hi_sum;
  logic                     last;
  logic signed [PROD_W-1:0] full;

  assign last   = short_r ? (cnt_r == 6'(DT_FRAC_BITS)) : (cnt_r == 6'(MUL_BW - 1));
  assign addend = !lo_r[0] ? '0 : (last ? -(MUL_AW+1)'(a_r) : (MUL_AW+1)'(a_r));
  assign hi_sum = hi_r + addend;
  assign full   = {hi_r, lo_r};
  assign prod   = short_r ? (full >>> (MUL_BW - DT_FRAC_BITS - 1)) : full;
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        short_r <= short_op;
        a_r     <= a;
        hi_r    <= '0;
        lo_r    <= b;
      end else if (busy_r) begin
        hi_r  <= {hi_sum[MUL_AW], hi_sum[MUL_AW:1]};
        lo_r  <= {hi_sum[0], lo_r[MUL_BW-1:1]};
        cnt_r <= cnt_r + 6'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/akf_div.sv @@
// Restoring divider for the Kalman gain, one quotient bit per cycle.
module akf_div
  import akf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] p,
  input  logic        [32:0] s,
  output logic               done,
  output akf_sat_t           gain
);

  localparam int NW = 32 + COV_FRAC_BITS + 1;

  logic          busy_r;
  logic          done_r;
  logic [4:0]    cnt_r;
  logic [32:0]   rem_r;
  logic [31:0]   num_r;
  logic [32:0]   s_r;
  logic          neg_r;
  logic          ovf_r;
  logic [31:0]   mag;
  logic [NW-1:0] numer;
  logic [NW-33:0] numer_hi;
  logic [33:0]   r2;
  logic          ge;
  logic [31:0]   qc;

  assign mag      = p[31] ? 32'(-33'(p)) : 32'(p);
  assign numer    = (NW'(mag) << COV_FRAC_BITS) + NW'(s >> 1);
  assign numer_hi = numer[NW-1:32];
  assign r2       = {rem_r, num_r[31]};
  assign ge       = r2 >= {1'b0, s_r};
  assign done     = done_r;

  always_comb begin
    qc = num_r;
    if (ovf_r || (num_r[31] && (num_r[30:0] != '0))) begin
      qc = 32'h8000_0000;
    end
    gain.flag = 1'b0;
    if (neg_r) begin
      gain.val = -qc;
    end else if (qc[31]) begin
      gain.val  = 32'sh7FFF_FFFF;
      gain.flag = 1'b1;
    end else begin
      gain.val = qc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        s_r    <= s;
        neg_r  <= p[31];
        ovf_r  <= 33'(numer_hi) >= s;
        rem_r  <= 33'(numer_hi);
        num_r  <= numer[31:0];
      end else if (busy_r) begin
        rem_r <= ge ? 33'(r2 - {1'b0, s_r}) : r2[32:0];
        num_r <= {num_r[30:0], ge};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/angle_kalman_filter.sv @@
// A beat ends early, after the covariance prediction, when the innovation
// variance is not positive. One beat is in work at a time.
// Throughput is set by the bit-serial multiplier (one multiplier bit per cycle,
// ten products) and the restoring divider (one quotient bit per cycle, two gains).
// Synchronous active-low reset restores the initial state and noise registers.
// Angle Kalman filter top level: sequencer, state and configuration registers.
module angle_kalman_filter
  import akf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  akf_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output akf_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NOISE_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  localparam logic [3:0] ST_ANGLE = 4'd0;
  localparam logic [3:0] ST_T     = 4'd1;
  localparam logic [3:0] ST_PAA   = 4'd2;
  localparam logic [3:0] ST_PBB   = 4'd3;
  localparam logic [3:0] ST_K0    = 4'd4;
  localparam logic [3:0] ST_K1    = 4'd5;
  localparam logic [3:0] ST_UA    = 4'd6;
  localparam logic [3:0] ST_UB    = 4'd7;
  localparam logic [3:0] ST_UBB   = 4'd8;
  localparam logic [3:0] ST_UBA   = 4'd9;
  localparam logic [3:0] ST_UAB   = 4'd10;
  localparam logic [3:0] ST_UAA   = 4'd11;

  state_t state_r, state_nxt;
  logic [3:0] step_r;

  logic signed [31:0] ae_r, bias_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [31:0] k0_r, k1_r, delta_r, z_r, w_r;
  logic signed [33:0] t_r;
  logic        [15:0] dt_r;
  logic        [32:0] s_r;
  logic [NOISE_W-1:0] qa_r, qg_r, rn_r;
  logic               sat_r;
  logic               out_valid_r;
  akf_out_t           out_data_r;

  logic                     mul_start, div_start, mul_done, div_done, unit_done;
  logic                     short_op;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [31:0]       div_p;
  akf_sat_t                 gain;

  logic signed [WIDE_W-1:0] pw, r16, rc, base16, basec, s_w;
  akf_sat_t acc16, accc, nab, nba, delta;
  logic     s_nonpos, last_step;

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mul_start = (state_r == S_ISSUE) && (step_r != ST_K0) && (step_r != ST_K1);
  assign div_start = (state_r == S_ISSUE) && ((step_r == ST_K0) || (step_r == ST_K1));
  assign unit_done = mul_done || div_done;
  assign short_op  = step_r <= ST_PBB;
  assign div_p     = (step_r == ST_K0) ? aa_r : ba_r;

  always_comb begin
    mul_a = '0;
    mul_b = MUL_BW'({1'b0, dt_r});
    unique case (step_r)
      ST_ANGLE: mul_a = MUL_AW'(w_r) - MUL_AW'(bias_r);
      ST_T:     mul_a = MUL_AW'(bb_r);
      ST_PAA:   mul_a = MUL_AW'(t_r) - MUL_AW'(ba_r) - MUL_AW'(ab_r)
                        + MUL_AW'({1'b0, qa_r});
      ST_PBB:   mul_a = MUL_AW'({1'b0, qg_r});
      ST_UA: begin
        mul_a = MUL_AW'(k0_r);
        mul_b = MUL_BW'(delta_r);
      end
      ST_UB: begin
        mul_a = MUL_AW'(k1_r);
        mul_b = MUL_BW'(delta_r);
      end
      ST_UBB: begin
        mul_a = MUL_AW'(ab_r);
        mul_b = MUL_BW'(k1_r);
      end
      ST_UBA: begin
        mul_a = MUL_AW'(aa_r);
        mul_b = MUL_BW'(k1_r);
      end
      ST_UAB: begin
        mul_a = MUL_AW'(ab_r);
        mul_b = MUL_BW'(k0_r);
      end
      ST_UAA: begin
        mul_a = MUL_AW'(aa_r);
        mul_b = MUL_BW'(k0_r);
      end
      default: mul_a = '0;
    endcase
  end

  akf_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_start),
    .short_op (short_op),
    .a        (mul_a),
    .b        (mul_b),
    .done     (mul_done),
    .prod     (prod)
  );

  akf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .p     (div_p),
    .s     (s_r),
    .done  (div_done),
    .gain  (gain)
  );

  assign pw  = WIDE_W'(prod);
  assign r16 = (pw + (WIDE_W'(1) <<< (DT_FRAC_BITS - 1))) >>> DT_FRAC_BITS;
  assign rc  = (pw + (WIDE_W'(1) <<< (COV_FRAC_BITS - 1))) >>> COV_FRAC_BITS;

  always_comb begin
    base16 = WIDE_W'(ae_r);
    basec  = WIDE_W'(ae_r);
    unique case (step_r)
      ST_PAA:  base16 = WIDE_W'(aa_r);
      ST_PBB:  base16 = WIDE_W'(bb_r);
      ST_UB:   basec  = WIDE_W'(bias_r);
      ST_UBB:  basec  = WIDE_W'(bb_r);
      ST_UBA:  basec  = WIDE_W'(ba_r);
      ST_UAB:  basec  = WIDE_W'(ab_r);
      ST_UAA:  basec  = WIDE_W'(aa_r);
      default: base16 = WIDE_W'(ae_r);
    endcase
  end

  assign acc16     = sat32(base16 + r16);
  assign accc      = sat32(((step_r == ST_UA) || (step_r == ST_UB)) ? basec + rc : basec - rc);
  assign nab       = sat32(WIDE_W'(ab_r) - WIDE_W'(t_r));
  assign nba       = sat32(WIDE_W'(ba_r) - WIDE_W'(t_r));
  assign delta     = sat32(WIDE_W'(z_r) - WIDE_W'(ae_r));
  assign s_w       = WIDE_W'(aa_r) + WIDE_W'({1'b0, rn_r});
  assign s_nonpos  = s_w <= 0;
  assign last_step = step_r == ST_UAA;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_ISSUE;
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (unit_done) begin
          if (last_step || ((step_r == ST_PBB) && s_nonpos)) state_nxt = S_DONE;
          else state_nxt = S_ISSUE;
        end
      end
      S_DONE:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_ANGLE;
      out_valid_r <= 1'b0;
      sat_r       <= 1'b0;
      ae_r        <= '0;
      bias_r      <= '0;
      aa_r        <= COV_ONE;
      ab_r        <= '0;
      ba_r        <= '0;
      bb_r        <= COV_ONE;
      qa_r        <= Q_ANGLE_RST;
      qg_r        <= Q_BIAS_RST;
      rn_r        <= R_MEAS_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        priority if (cfg_index == CFG_Q_ANGLE) qa_r <= cfg_data;
        else if (cfg_index == CFG_Q_BIAS) qg_r <= cfg_data;
        else if (cfg_index == CFG_R_MEAS) rn_r <= cfg_data;
      end
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            z_r    <= in_data.measured_angle;
            w_r    <= in_data.gyro_rate;
            dt_r   <= in_data.time_step;
            sat_r  <= 1'b0;
            step_r <= ST_ANGLE;
          end
        end
        S_ISSUE: step_r <= step_r;
        S_WAIT: begin
          if (unit_done) begin
            step_r <= step_r + 4'd1;
            unique case (step_r)
              ST_ANGLE: begin
                ae_r  <= acc16.val;
                sat_r <= sat_r | acc16.flag;
              end
              ST_T: t_r <= r16[33:0];
              ST_PAA: begin
                aa_r  <= acc16.val;
                ab_r  <= nab.val;
                ba_r  <= nba.val;
                sat_r <= sat_r | acc16.flag | nab.flag | nba.flag;
              end
              ST_PBB: begin
                bb_r  <= acc16.val;
                s_r   <= s_w[32:0];
                sat_r <= sat_r | acc16.flag | s_nonpos;
              end
              ST_K0: begin
                k0_r  <= gain.val;
                sat_r <= sat_r | gain.flag;
              end
              ST_K1: begin
                k1_r    <= gain.val;
                delta_r <= delta.val;
                sat_r   <= sat_r | gain.flag | delta.flag;
              end
              ST_UA: begin
                ae_r  <= accc.val;
                sat_r <= sat_r | accc.flag;
              end
              ST_UB: begin
                bias_r <= accc.val;
                sat_r  <= sat_r | accc.flag;
              end
              ST_UBB: begin
                bb_r  <= accc.val;
                sat_r <= sat_r | accc.flag;
              end
              ST_UBA: begin
                ba_r  <= accc.val;
                sat_r <= sat_r | accc.flag;
              end
              ST_UAB: begin
                ab_r  <= accc.val;
                sat_r <= sat_r | accc.flag;
              end
              ST_UAA: begin
                aa_r  <= accc.val;
                sat_r <= sat_r | accc.flag;
              end
              default: sat_r <= sat_r;
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.angle_out <= ae_r;
            out_data_r.bias_out  <= bias_r;
            out_data_r.saturated <= sat_r;
          end
        end
        default: step_r <= step_r;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_div_step: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (step_r == ST_K0 || step_r == ST_K1))
    else $error("divider finished outside a gain step");

  a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_ISSUE && step_r == ST_ANGLE))
    else $error("accepted beat did not start the sequence");
`endif

endmodule
